// ===== hdl/sha256_pow_hash_chain_core_macros.svh =====
// ----------------------------------------------------------------------------
// sha256 pow hash chain core assertion macros
// concurrent assertion wrappers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef SHA256_POW_HASH_CHAIN_CORE_MACROS_SVH
`define SHA256_POW_HASH_CHAIN_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SHAPOW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHAPOW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHAPOW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SHAPOW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/shapow_pkg.sv =====
// ----------------------------------------------------------------------------
// shapow package
// shared types, constants and functions of the sha256 pow hash chain core
// ----------------------------------------------------------------------------
package shapow_pkg;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned WIN_DEPTH  = 16;
    localparam logic [6:0]  LEVEL_CAP  = 7'd64;
    localparam logic [6:0]  MAX_LEVEL_RESET = 7'd8;
    localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
    localparam logic [31:0] LEN_WORD   = 32'd288;

    localparam logic [2:0] REG_SEED0     = 3'd0;
    localparam logic [2:0] REG_SEED1     = 3'd1;
    localparam logic [2:0] REG_SEED2     = 3'd2;
    localparam logic [2:0] REG_SEED3     = 3'd3;
    localparam logic [2:0] REG_MAX_LEVEL = 3'd4;

    localparam logic CMD_TRY     = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } work_t;

    localparam work_t HINIT = '{
        a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
        e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
    };

    localparam logic [31:0] RK [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // top 4*lvl bits of the digest are zero (a lvl above 64 checks all 256 bits)
    function automatic logic top_zero(input logic [255:0] dig, input logic [6:0] lvl);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 64; i++) begin
            if ((7'(i) < lvl) && (dig[255 - 4 * i -: 4] != 4'd0)) begin
                ok = 1'b0;
            end
        end
        top_zero = ok;
    endfunction

endpackage

// ===== hdl/shapow_round.sv =====
// ----------------------------------------------------------------------------
// shapow round unit
// one sha256 compression round plus one message schedule step
// ----------------------------------------------------------------------------
module shapow_round
(
    input  shapow_pkg::work_t cur,
    input  logic [31:0]       w_0,
    input  logic [31:0]       w_1,
    input  logic [31:0]       w_9,
    input  logic [31:0]       w_14,
    input  logic [31:0]       k,
    output shapow_pkg::work_t nxt,
    output logic [31:0]       w_new
);

    logic [31:0] s1_big;
    logic [31:0] ch;
    logic [31:0] t1;
    logic [31:0] s0_big;
    logic [31:0] maj;
    logic [31:0] t2;
    logic [31:0] s0_sch;
    logic [31:0] s1_sch;

    always_comb
    begin
        s1_big = shapow_pkg::rotr(cur.e, 6) ^ shapow_pkg::rotr(cur.e, 11)
               ^ shapow_pkg::rotr(cur.e, 25);
        ch     = (cur.e & cur.f) ^ (~cur.e & cur.g);
        t1     = cur.h + s1_big + ch + k + w_0;
        s0_big = shapow_pkg::rotr(cur.a, 2) ^ shapow_pkg::rotr(cur.a, 13)
               ^ shapow_pkg::rotr(cur.a, 22);
        maj    = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
        t2     = s0_big + maj;
        nxt.h  = cur.g;
        nxt.g  = cur.f;
        nxt.f  = cur.e;
        nxt.e  = cur.d + t1;
        nxt.d  = cur.c;
        nxt.c  = cur.b;
        nxt.b  = cur.a;
        nxt.a  = t1 + t2;
        s0_sch = shapow_pkg::rotr(w_1, 7) ^ shapow_pkg::rotr(w_1, 18) ^ (w_1 >> 3);
        s1_sch = shapow_pkg::rotr(w_14, 17) ^ shapow_pkg::rotr(w_14, 19) ^ (w_14 >> 10);
        w_new  = w_0 + s0_sch + w_9 + s1_sch;
    end

endmodule

// ===== hdl/sha256_pow_hash_chain_core.sv =====
// ----------------------------------------------------------------------------
// sha256 pow hash chain core
// nonce trials against a sha256 chain hash, one shared round unit
// ----------------------------------------------------------------------------
// channel  direction  handshake                payload
// in       sink       in_valid / in_ready      command, nonce
// out      source     out_valid / out_ready    found, level, nonce_echo,
//                                              digest_word0..3, chain_done
// cfg      sink       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// a trial runs the accept in idle, 64 rounds through the single round unit,
// one final add and one compare/write; a restart goes from idle to the write
// step; in_ready is high only in idle; a full output register holds the write
// step; reset clears the chain hash and level, max level resets to 8
// ----------------------------------------------------------------------------
`include "sha256_pow_hash_chain_core_macros.svh"

module sha256_pow_hash_chain_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [30:0] nonce,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [6:0]  level,
    output logic [30:0] nonce_echo,
    output logic [63:0] digest_word0,
    output logic [63:0] digest_word1,
    output logic [63:0] digest_word2,
    output logic [63:0] digest_word3,
    output logic        chain_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    shapow_pkg::state_t state_reg, state_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic         cmd_reg, cmd_next;
    logic [30:0]  nonce_reg, nonce_next;
    shapow_pkg::work_t work_reg, work_next, work_rnd;
    logic [31:0]  win_reg [shapow_pkg::WIN_DEPTH];
    logic [31:0]  win_next [shapow_pkg::WIN_DEPTH];
    logic [31:0]  w_new;
    logic [255:0] dig_reg, dig_next;
    logic [255:0] chain_reg, chain_next;
    logic [255:0] seed_reg, seed_next;
    logic [6:0]   max_reg, max_next;
    logic [6:0]   level_reg, level_next;
    logic         fin_reg, fin_next;
    logic         ov_reg, ov_next;
    logic         found_reg, found_next;
    logic [6:0]   olvl_reg, olvl_next;
    logic [30:0]  onon_reg, onon_next;
    logic [255:0] odig_reg, odig_next;
    logic         odone_reg, odone_next;
    logic [6:0]   eff_max;
    logic         hit;
    logic         in_acc;

    shapow_round u_round
    (
        .cur   (work_reg),
        .w_0   (win_reg[0]),
        .w_1   (win_reg[1]),
        .w_9   (win_reg[9]),
        .w_14  (win_reg[14]),
        .k     (shapow_pkg::RK[rnd_reg]),
        .nxt   (work_rnd),
        .w_new (w_new)
    );

    assign in_ready     = (state_reg == shapow_pkg::ST_IDLE);
    assign in_acc       = in_valid && in_ready;
    assign cfg_ready    = 1'b1;
    assign out_valid    = ov_reg;
    assign found        = found_reg;
    assign level        = olvl_reg;
    assign nonce_echo   = onon_reg;
    assign digest_word0 = odig_reg[255:192];
    assign digest_word1 = odig_reg[191:128];
    assign digest_word2 = odig_reg[127:64];
    assign digest_word3 = odig_reg[63:0];
    assign chain_done   = odone_reg;

    assign eff_max = (max_reg > shapow_pkg::LEVEL_CAP) ? shapow_pkg::LEVEL_CAP : max_reg;
    assign hit     = !fin_reg && shapow_pkg::top_zero(dig_reg, level_reg);

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        cmd_next   = cmd_reg;
        nonce_next = nonce_reg;
        work_next  = work_reg;
        win_next   = win_reg;
        dig_next   = dig_reg;
        chain_next = chain_reg;
        seed_next  = seed_reg;
        max_next   = max_reg;
        level_next = level_reg;
        fin_next   = fin_reg;
        ov_next    = ov_reg;
        found_next = found_reg;
        olvl_next  = olvl_reg;
        onon_next  = onon_reg;
        odig_next  = odig_reg;
        odone_next = odone_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                shapow_pkg::REG_SEED0:     seed_next[255:192] = cfg_data;
                shapow_pkg::REG_SEED1:     seed_next[191:128] = cfg_data;
                shapow_pkg::REG_SEED2:     seed_next[127:64]  = cfg_data;
                shapow_pkg::REG_SEED3:     seed_next[63:0]    = cfg_data;
                shapow_pkg::REG_MAX_LEVEL: max_next = cfg_data[6:0];
                default:                   max_next = max_reg;
            endcase
        end

        case (state_reg)
            shapow_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next   = command;
                    nonce_next = nonce;
                    rnd_next   = '0;
                    work_next  = shapow_pkg::HINIT;
                    for (int i = 0; i < 8; i++)
                    begin
                        win_next[i] = chain_reg[255 - 32 * i -: 32];
                    end
                    win_next[8]  = {1'b0, nonce};
                    win_next[9]  = shapow_pkg::PAD_WORD;
                    for (int i = 10; i < 15; i++)
                    begin
                        win_next[i] = '0;
                    end
                    win_next[15] = shapow_pkg::LEN_WORD;
                    if (command == shapow_pkg::CMD_RESTART)
                    begin
                        dig_next   = seed_reg;
                        state_next = shapow_pkg::ST_WRITE;
                    end
                    else
                    begin
                        state_next = shapow_pkg::ST_ROUND;
                    end
                end
            end
            shapow_pkg::ST_ROUND:
            begin
                work_next = work_rnd;
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = w_new;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == 6'(shapow_pkg::NUM_ROUNDS - 1))
                begin
                    state_next = shapow_pkg::ST_ADD;
                end
            end
            shapow_pkg::ST_ADD:
            begin
                dig_next = {shapow_pkg::HINIT.a + work_reg.a, shapow_pkg::HINIT.b + work_reg.b,
                            shapow_pkg::HINIT.c + work_reg.c, shapow_pkg::HINIT.d + work_reg.d,
                            shapow_pkg::HINIT.e + work_reg.e, shapow_pkg::HINIT.f + work_reg.f,
                            shapow_pkg::HINIT.g + work_reg.g, shapow_pkg::HINIT.h + work_reg.h};
                state_next = shapow_pkg::ST_WRITE;
            end
            shapow_pkg::ST_WRITE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    onon_next  = nonce_reg;
                    odig_next  = dig_reg;
                    state_next = shapow_pkg::ST_IDLE;
                    if (cmd_reg == shapow_pkg::CMD_RESTART)
                    begin
                        chain_next = dig_reg;
                        level_next = '0;
                        fin_next   = 1'b0;
                        found_next = 1'b0;
                        olvl_next  = '0;
                        odone_next = 1'b0;
                    end
                    else
                    begin
                        found_next = hit;
                        olvl_next  = level_reg;
                        odone_next = fin_reg;
                        if (hit)
                        begin
                            chain_next = dig_reg;
                            level_next = level_reg + 7'd1;
                            if ((level_reg + 7'd1) > eff_max)
                            begin
                                fin_next   = 1'b1;
                                odone_next = 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = shapow_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shapow_pkg::ST_IDLE;
            chain_reg <= '0;
            seed_reg  <= '0;
            max_reg   <= shapow_pkg::MAX_LEVEL_RESET;
            level_reg <= '0;
            fin_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            rnd_reg   <= '0;
            cmd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            seed_reg  <= seed_next;
            max_reg   <= max_next;
            level_reg <= level_next;
            fin_reg   <= fin_next;
            ov_reg    <= ov_next;
            rnd_reg   <= rnd_next;
            cmd_reg   <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nonce_reg <= nonce_next;
        work_reg  <= work_next;
        win_reg   <= win_next;
        dig_reg   <= dig_next;
        found_reg <= found_next;
        olvl_reg  <= olvl_next;
        onon_reg  <= onon_next;
        odig_reg  <= odig_next;
        odone_reg <= odone_next;
    end

    // trial requests enter the round loop, restarts go straight to write
    `SHAPOW_ASSERT_NXT(a_accept_path, clk, rst_n, in_acc,
        (state_reg == shapow_pkg::ST_ROUND) || (state_reg == shapow_pkg::ST_WRITE))
    // last round is always followed by the final add
    `SHAPOW_ASSERT_NXT(a_round_end, clk, rst_n,
        (state_reg == shapow_pkg::ST_ROUND) && (rnd_reg == 6'd63),
        state_reg == shapow_pkg::ST_ADD)
    // chain level never passes the cap plus one
    `SHAPOW_ASSERT_IMP(a_level_range, clk, rst_n, 1'b1, level_reg <= 7'd65)
    // a find never reports a level above the cap
    `SHAPOW_ASSERT_IMP(a_found_level, clk, rst_n, ov_reg && found_reg,
        (olvl_reg <= shapow_pkg::LEVEL_CAP) && !(fin_reg && !odone_reg && (level_reg == '0)))

endmodule
